// File: src/bce_pkg.sv
// Shared types and constants for the Bezier curve evaluator.
// No dependencies; imported by the front end, job queue, back end and top level.
package bce_pkg;

    localparam int unsigned NW = 6;               // job point-index width (n <= 32)
    localparam int unsigned MW = 7;               // curve point count width
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [30:0] TSNAP_Q30 = 31'd5369;
    localparam int unsigned BINW = 30;            // C(32,16) fits in 30 bits

    typedef struct packed {
        logic [NW-1:0] n;      // stored points - 1
        logic [MW-1:0] m;      // curve points to emit
        logic          drop;   // points were dropped
    } t_job;

endpackage

// File: src/bce_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module bce_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/bce_front.sv
// Front end: accepts control point beats, writes the point store, holds the
// curve point count register and issues one job per curve. Uses bce_pkg.
module bce_front #(
    parameter int unsigned MAX_CTRL_POINTS  = 16,
    parameter int unsigned MAX_CURVE_POINTS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [31:0]                        i_point_x,
    input  logic [31:0]                        i_point_y,
    input  logic                               i_last_point,
    input  logic                               i_wr_en,
    input  logic [bce_pkg::MW-1:0]             i_wr_data,
    output logic                               o_st_we,
    output logic [$clog2(MAX_CTRL_POINTS)-1:0] o_st_waddr,
    output logic [31:0]                        o_st_x,
    output logic [31:0]                        o_st_y,
    output logic                               o_push,
    output bce_pkg::t_job                      o_job,
    input  logic                               i_done
);
    import bce_pkg::*;

    localparam int unsigned AW = $clog2(MAX_CTRL_POINTS);
    localparam int unsigned CW = $clog2(MAX_CTRL_POINTS + 1);

    logic [CW-1:0] r_count;
    logic          r_drop;
    logic          r_hold;
    logic [MW-1:0] r_num_points;
    logic          acc;
    logic          full;
    logic [CW-1:0] cnt_next;
    logic [MW-1:0] m_clamp;

    assign o_stall  = r_hold;
    assign acc      = i_valid && !r_hold;
    assign full     = (r_count == CW'(MAX_CTRL_POINTS));
    assign cnt_next = full ? r_count : r_count + CW'(1);

    always_comb begin
        if (r_num_points == '0) begin
            m_clamp = MW'(1);
        end else if (r_num_points > MW'(MAX_CURVE_POINTS)) begin
            m_clamp = MW'(MAX_CURVE_POINTS);
        end else begin
            m_clamp = r_num_points;
        end
    end

    assign o_st_we    = acc && !full;
    assign o_st_waddr = r_count[AW-1:0];
    assign o_st_x     = i_point_x;
    assign o_st_y     = i_point_y;
    assign o_push     = acc && i_last_point;
    assign o_job.n    = NW'(cnt_next - CW'(1));
    assign o_job.m    = m_clamp;
    assign o_job.drop = r_drop || full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_drop       <= 1'b0;
            r_hold       <= 1'b0;
            r_num_points <= MW'(64);
        end else begin
            if (i_wr_en) begin
                r_num_points <= i_wr_data;
            end
            if (acc) begin
                if (i_last_point) begin
                    r_count <= '0;
                    r_drop  <= 1'b0;
                    r_hold  <= 1'b1;
                end else begin
                    r_count <= cnt_next;
                    r_drop  <= r_drop || full;
                end
            end else if (i_done) begin
                r_hold <= 1'b0;
            end
        end
    end

    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_st_we |-> r_count < CW'(MAX_CTRL_POINTS))
        else $error("store written while full");
    a_push_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_count == '0) && r_hold)
        else $error("curve start did not clear the point count");
    a_drop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && full && !i_last_point |=> r_drop)
        else $error("dropped point not flagged");

endmodule

// File: src/bce_jobq.sv
// Two-entry job queue between the front end and the evaluation back end.
// Uses bce_pkg for the job type.
module bce_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bce_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_nonempty,
    output bce_pkg::t_job o_job
);
    import bce_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_nonempty = (r_cnt != 2'd0);
    assign o_job      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// File: src/bce_back.sv
// Back end: per job builds the binomial row and the step of t, then for each
// curve point sums the weighted control points on one shared multiplier.
// Uses bce_pkg and bce_ram.
module bce_back #(
    parameter int unsigned MAX_CTRL_POINTS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_job_valid,
    input  bce_pkg::t_job                      i_job,
    output logic                               o_job_pop,
    output logic [$clog2(MAX_CTRL_POINTS)-1:0] o_st_raddr,
    input  logic [31:0]                        i_st_x,
    input  logic [31:0]                        i_st_y,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [31:0]                        o_curve_x,
    output logic [31:0]                        o_curve_y,
    output logic                               o_last_sample,
    output logic                               o_overflow,
    output logic                               o_done
);
    import bce_pkg::*;

    localparam int unsigned AW = $clog2(MAX_CTRL_POINTS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_PINIT = 4'd2;
    localparam logic [3:0] S_PRD   = 4'd3;
    localparam logic [3:0] S_PWR   = 4'd4;
    localparam logic [3:0] S_POINT = 4'd5;
    localparam logic [3:0] S_UMUL  = 4'd6;
    localparam logic [3:0] S_UWR   = 4'd7;
    localparam logic [3:0] S_ERD   = 4'd8;
    localparam logic [3:0] S_EM1   = 4'd9;
    localparam logic [3:0] S_EM2   = 4'd10;
    localparam logic [3:0] S_EM3   = 4'd11;
    localparam logic [3:0] S_EM4   = 4'd12;
    localparam logic [3:0] S_EM5   = 4'd13;
    localparam logic [3:0] S_EM6   = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    function automatic logic [31:0] f_finish(input logic signed [65:0] a);
        logic signed [65:0] s;
        s = a >>> 30;
        if (s > 66'sd2147483647) begin
            f_finish = 32'h7fff_ffff;
        end else if (s < -66'sd2147483648) begin
            f_finish = 32'h8000_0000;
        end else begin
            f_finish = s[31:0];
        end
    endfunction

    logic [3:0]         r_state;
    t_job               r_job;
    logic [4:0]         r_dcnt;
    logic [30:0]        r_dq;      // quotient: 2^30 / (m-1)
    logic [5:0]         r_dr;      // remainder
    logic [30:0]        r_tq;
    logic [6:0]         r_tr;
    logic [MW-1:0]      r_k;
    logic [NW-1:0]      r_row;
    logic [NW-1:0]      r_j;
    logic [NW-1:0]      r_i;
    logic [BINW-1:0]    r_prev;
    logic [30:0]        r_t;
    logic [30:0]        r_u;
    logic [30:0]        r_up;
    logic [30:0]        r_tp;
    logic [BINW-1:0]    r_c;
    logic [31:0]        r_px;
    logic [31:0]        r_py;
    logic [31:0]        r_b;
    logic signed [65:0] r_mp;
    logic signed [65:0] r_ax;
    logic signed [65:0] r_ay;
    logic               r_ovalid;
    logic [31:0]        r_ox;
    logic [31:0]        r_oy;
    logic               r_olast;
    logic               r_oovf;

    logic [5:0]         d;
    logic [6:0]         rem_s;
    logic               ge;
    logic [30:0]        t_c;
    logic [30:0]        mp30;
    logic signed [32:0] ma;
    logic signed [32:0] mb;
    logic               b_we;
    logic [AW-1:0]      b_waddr;
    logic [BINW-1:0]    b_wdata;
    logic [AW-1:0]      b_raddr;
    logic [BINW-1:0]    b_rdata;
    logic [BINW-1:0]    b_old;
    logic               u_we;
    logic [AW-1:0]      u_waddr;
    logic [30:0]        u_wdata;
    logic [AW-1:0]      u_raddr;
    logic [30:0]        u_rdata;
    logic               can_load;
    logic               is_last;
    logic [6:0]         tr_sum;

    assign d      = 6'(r_job.m - MW'(1));
    assign rem_s  = {r_dr, r_dq[30]};
    assign ge     = (rem_s >= {1'b0, d});
    assign t_c    = ((Q30_ONE - r_tq) < TSNAP_Q30) ? Q30_ONE : r_tq;
    assign mp30   = r_mp[60:30];
    assign b_old  = (r_j == r_row) ? '0 : b_rdata;
    assign tr_sum = r_tr + {1'b0, r_dr};

    assign can_load  = !r_ovalid || !i_stall;
    assign is_last   = (r_k == r_job.m - MW'(1));
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign o_done    = (r_state == S_OUT) && can_load && is_last;
    assign o_st_raddr = r_i[AW-1:0];

    always_comb begin
        ma = '0;
        mb = '0;
        case (r_state)
            S_UMUL: begin
                ma = $signed({2'b00, r_up});
                mb = $signed({2'b00, r_u});
            end
            S_EM1: begin
                ma = $signed({2'b00, u_rdata});
                mb = $signed({2'b00, r_tp});
            end
            S_EM2: begin
                ma = $signed({2'b00, mp30});
                mb = $signed({3'b000, r_c});
            end
            S_EM3: begin
                ma = $signed({2'b00, r_tp});
                mb = $signed({2'b00, r_t});
            end
            S_EM4: begin
                ma = $signed({1'b0, r_b});
                mb = $signed({r_px[31], r_px});
            end
            S_EM5: begin
                ma = $signed({1'b0, r_b});
                mb = $signed({r_py[31], r_py});
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign b_we    = (r_state == S_PINIT) || (r_state == S_PWR);
    assign b_waddr = (r_state == S_PINIT) ? '0 : r_j[AW-1:0];
    assign b_wdata = (r_state == S_PINIT) ? BINW'(1) : r_prev + b_old;
    assign b_raddr = (r_state == S_ERD) ? r_i[AW-1:0] : r_j[AW-1:0];

    assign u_we    = (r_state == S_POINT) || (r_state == S_UWR);
    assign u_waddr = (r_state == S_POINT) ? '0 : r_j[AW-1:0];
    assign u_wdata = (r_state == S_POINT) ? Q30_ONE : mp30;
    assign u_raddr = AW'(r_job.n - r_i);

    bce_ram #(.WIDTH(BINW), .DEPTH(MAX_CTRL_POINTS)) u_binom (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    bce_ram #(.WIDTH(31), .DEPTH(MAX_CTRL_POINTS)) u_upow (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_raddr (u_raddr),
        .o_rdata (u_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_mp <= ma * mb;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job <= i_job;
                r_dq  <= Q30_ONE;
                r_dr  <= '0;
                r_dcnt <= '0;
            end
            S_DIV: begin
                r_dq   <= {r_dq[29:0], ge};
                r_dr   <= ge ? 6'(rem_s - {1'b0, d}) : rem_s[5:0];
                r_dcnt <= r_dcnt + 5'd1;
            end
            S_PINIT: begin
                if (d == '0) begin
                    r_dq <= '0;
                    r_dr <= '0;
                end
                r_tq   <= '0;
                r_tr   <= '0;
                r_k    <= '0;
                r_row  <= NW'(1);
                r_j    <= NW'(1);
                r_prev <= BINW'(1);
            end
            S_PWR: begin
                if (r_j == r_row) begin
                    r_row  <= r_row + NW'(1);
                    r_j    <= NW'(1);
                    r_prev <= BINW'(1);
                end else begin
                    r_j    <= r_j + NW'(1);
                    r_prev <= b_old;
                end
            end
            S_POINT: begin
                r_t  <= t_c;
                r_u  <= Q30_ONE - t_c;
                r_up <= Q30_ONE;
                r_j  <= NW'(1);
                r_i  <= '0;
                r_tp <= Q30_ONE;
                r_ax <= '0;
                r_ay <= '0;
            end
            S_UWR: begin
                r_up <= mp30;
                r_j  <= r_j + NW'(1);
            end
            S_EM1: begin
                r_c  <= b_rdata;
                r_px <= i_st_x;
                r_py <= i_st_y;
            end
            S_EM3: begin
                r_b <= r_mp[31:0];
            end
            S_EM4: begin
                r_tp <= mp30;
            end
            S_EM5: begin
                r_ax <= r_ax + r_mp;
            end
            S_EM6: begin
                r_ay <= r_ay + r_mp;
                r_i  <= r_i + NW'(1);
            end
            S_OUT: begin
                if (can_load) begin
                    r_ox    <= f_finish(r_ax);
                    r_oy    <= f_finish(r_ay);
                    r_olast <= is_last;
                    r_oovf  <= r_job.drop;
                    r_k     <= r_k + MW'(1);
                    if (tr_sum >= {1'b0, d}) begin
                        r_tr <= tr_sum - {1'b0, d};
                        r_tq <= r_tq + r_dq + 31'd1;
                    end else begin
                        r_tr <= tr_sum;
                        r_tq <= r_tq + r_dq;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && can_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_dcnt == 5'd30) begin
                        r_state <= S_PINIT;
                    end
                end
                S_PINIT: begin
                    r_state <= (r_job.n == '0) ? S_POINT : S_PRD;
                end
                S_PRD: begin
                    r_state <= S_PWR;
                end
                S_PWR: begin
                    if ((r_j == r_row) && (r_row == r_job.n)) begin
                        r_state <= S_POINT;
                    end else begin
                        r_state <= S_PRD;
                    end
                end
                S_POINT: begin
                    r_state <= (r_job.n == '0) ? S_ERD : S_UMUL;
                end
                S_UMUL: begin
                    r_state <= S_UWR;
                end
                S_UWR: begin
                    r_state <= (r_j == r_job.n) ? S_ERD : S_UMUL;
                end
                S_ERD: begin
                    r_state <= S_EM1;
                end
                S_EM1: begin
                    r_state <= S_EM2;
                end
                S_EM2: begin
                    r_state <= S_EM3;
                end
                S_EM3: begin
                    r_state <= S_EM4;
                end
                S_EM4: begin
                    r_state <= S_EM5;
                end
                S_EM5: begin
                    r_state <= S_EM6;
                end
                S_EM6: begin
                    r_state <= (r_i == r_job.n) ? S_OUT : S_ERD;
                end
                S_OUT: begin
                    if (can_load) begin
                        r_state <= is_last ? S_IDLE : S_POINT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_curve_x     = r_ox;
    assign o_curve_y     = r_oy;
    assign o_last_sample = r_olast;
    assign o_overflow    = r_oovf;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == S_IDLE))
        else $error("back end not idle after curve");
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERD) |-> (r_i <= r_job.n))
        else $error("control point index past job end");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dcnt <= 5'd30))
        else $error("divider ran too long");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && r_ovalid && i_stall |=> (r_state == S_OUT))
        else $error("result left while output register blocked");

endmodule

// File: src/bezier_curve_evaluator.sv
// Top level of the Bezier curve evaluator: front end, job queue, back end and
// the control point stores. Uses bce_pkg, bce_ram, bce_front, bce_jobq, bce_back.
//
// Usage:
//   Input channel (i_valid / o_stall): one control point per beat, Q16.16 x,y.
//   A beat with i_last_point set closes the curve; o_stall then stays high
//   until every curve point of that curve has been handed to the output register.
//   Points beyond MAX_CTRL_POINTS are dropped and reported on o_overflow.
//   Output channel (o_valid / i_stall): one curve point per beat, m beats per
//   curve, o_last_sample on the final one. The output register holds a
//   finished point while the next one is computed.
//   Config: i_wr_en writes i_wr_data to the curve point count (reset 64).
//   Non-last beats never raise o_stall. Per curve, the back end first runs
//   the reciprocal divider and builds the binomial row, then computes each
//   curve point on the single shared 33x33 multiplier. A stalled receiver
//   holds the back end at its output step while the output register is full.
//   Reset (synchronous, active low) clears the point count, drop flag, queue
//   and output valid, and sets the curve point count to 64.
module bezier_curve_evaluator #(
    parameter int unsigned MAX_CTRL_POINTS  = 16,
    parameter int unsigned MAX_CURVE_POINTS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [31:0]            i_point_x,
    input  logic [31:0]            i_point_y,
    input  logic                   i_last_point,
    input  logic                   i_wr_en,
    input  logic [bce_pkg::MW-1:0] i_wr_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [31:0]            o_curve_x,
    output logic [31:0]            o_curve_y,
    output logic                   o_last_sample,
    output logic                   o_overflow
);
    import bce_pkg::*;

    localparam int unsigned AW = $clog2(MAX_CTRL_POINTS);

    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [31:0]   st_x;
    logic [31:0]   st_y;
    logic [AW-1:0] st_raddr;
    logic [31:0]   st_rx;
    logic [31:0]   st_ry;
    logic          push;
    t_job          job_in;
    logic          pop;
    logic          q_nonempty;
    t_job          job_out;
    logic          done;

    bce_front #(
        .MAX_CTRL_POINTS  (MAX_CTRL_POINTS),
        .MAX_CURVE_POINTS (MAX_CURVE_POINTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_last_point (i_last_point),
        .i_wr_en      (i_wr_en),
        .i_wr_data    (i_wr_data),
        .o_st_we      (st_we),
        .o_st_waddr   (st_waddr),
        .o_st_x       (st_x),
        .o_st_y       (st_y),
        .o_push       (push),
        .o_job        (job_in),
        .i_done       (done)
    );

    bce_ram #(.WIDTH(32), .DEPTH(MAX_CTRL_POINTS)) u_store_x (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_x),
        .i_raddr (st_raddr),
        .o_rdata (st_rx)
    );

    bce_ram #(.WIDTH(32), .DEPTH(MAX_CTRL_POINTS)) u_store_y (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_y),
        .i_raddr (st_raddr),
        .o_rdata (st_ry)
    );

    bce_jobq u_jobq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (job_in),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_job      (job_out)
    );

    bce_back #(.MAX_CTRL_POINTS(MAX_CTRL_POINTS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_nonempty),
        .i_job         (job_out),
        .o_job_pop     (pop),
        .o_st_raddr    (st_raddr),
        .i_st_x        (st_rx),
        .i_st_y        (st_ry),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_curve_x     (o_curve_x),
        .o_curve_y     (o_curve_y),
        .o_last_sample (o_last_sample),
        .o_overflow    (o_overflow),
        .o_done        (done)
    );

endmodule
